FILE: rtl/core/sksid_pkg.sv
// sksid_pkg: constants and codes for the sorted key set
// no dependencies; used by sorted_key_set_insert_delete, sorted_key_set_checker and tb
`default_nettype none

package sksid_pkg;

    // store geometry
    localparam int CAPACITY = 16;
    localparam int KEY_W    = 32;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // port field widths
    localparam int STATUS_W = 2;
    localparam int ENTRY_W  = 5;

    // sign flip so that unsigned order matches signed order
    localparam logic [KEY_W-1:0] KEY_BIAS = {1'b1, {(KEY_W-1){1'b0}}};

    // request codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_DELETE = 1'b1;

    // status codes
    localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

endpackage

`default_nettype wire

FILE: rtl/core/sorted_key_set_insert_delete.sv
// sorted_key_set_insert_delete: sorted set of distinct signed keys, insert and delete
// depends on sksid_pkg; keys held in one synchronous single-read, single-write memory
//
//   channel | signals                        | direction
//   --------+--------------------------------+----------
//   request | in_valid, in_ready, cmd, key   | in
//   result  | out_valid, out_ready, status,  | out
//           | entry_count                    |
//
// one request at a time: each request is handled by one ascending pass over the
// stored keys through the memory read port, one key a cycle
// insert and delete shift the following keys by one entry during that same pass
// reset empties the store at once through the count register; no clearing pass
// a request may be accepted while the previous result waits in the output register
`default_nettype none

module sorted_key_set_insert_delete
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic                               cmd,
    input  wire logic signed [sksid_pkg::KEY_W-1:0] key,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [sksid_pkg::STATUS_W-1:0]          status,
    output logic [sksid_pkg::ENTRY_W-1:0]           entry_count
);

    localparam int KEY_W = sksid_pkg::KEY_W;
    localparam int IDX_W = sksid_pkg::IDX_W;
    localparam int CNT_W = sksid_pkg::CNT_W;

    // controller states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(sksid_pkg::CAPACITY);

    logic [1:0]                      state_reg, state_next;
    logic [CNT_W-1:0]                count_reg, count_next;
    logic [CNT_W-1:0]                rd_idx_reg, rd_idx_next;
    logic                            rvalid_reg, rvalid_next;
    logic [IDX_W-1:0]                didx_reg, didx_next;
    logic                            shift_reg, shift_next;
    logic                            cmd_reg, cmd_next;
    logic [KEY_W-1:0]                key_reg, key_next;
    logic [KEY_W-1:0]                carry_reg, carry_next;
    logic [sksid_pkg::STATUS_W-1:0]  res_reg, res_next;
    logic                            out_valid_reg, out_valid_next;
    logic [sksid_pkg::STATUS_W-1:0]  status_reg, status_next;
    logic [sksid_pkg::ENTRY_W-1:0]   entry_reg, entry_next;

    // key memory
    logic [KEY_W-1:0] mem [sksid_pkg::CAPACITY];
    logic [KEY_W-1:0] rdata_reg;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [KEY_W-1:0] mem_wdata;
    logic             mem_re;

    logic             full;
    logic             in_fire;
    logic             key_lt;
    logic             key_eq;

    assign in_ready    = (state_reg == S_IDLE);
    assign in_fire     = in_valid && in_ready;
    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign entry_count = entry_reg;

    assign full   = (count_reg == CAP_CNT);
    assign key_lt = (rdata_reg < key_reg);
    assign key_eq = (rdata_reg == key_reg);

    // memory write and registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[rd_idx_reg[IDX_W-1:0]];
        end
    end

    // scan, shift and result control
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rd_idx_next    = rd_idx_reg;
        rvalid_next    = 1'b0;
        didx_next      = didx_reg;
        shift_next     = shift_reg;
        cmd_next       = cmd_reg;
        key_next       = key_reg;
        carry_next     = carry_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        entry_next     = entry_reg;
        mem_we         = 1'b0;
        mem_waddr      = didx_reg;
        mem_wdata      = carry_reg;
        mem_re         = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd_next    = cmd;
                    key_next    = $unsigned(key) ^ sksid_pkg::KEY_BIAS;
                    rd_idx_next = '0;
                    shift_next  = 1'b0;
                    state_next  = S_SCAN;
                end
            end

            S_SCAN:
            begin
                if (rvalid_reg)
                begin
                    // key read in the previous cycle arrives
                    if (!shift_reg)
                    begin
                        if (key_eq)
                        begin
                            if (cmd_reg == sksid_pkg::CMD_INSERT)
                            begin
                                res_next   = sksid_pkg::ST_MISS;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                shift_next = 1'b1;
                            end
                        end
                        else if (!key_lt)
                        begin
                            if (cmd_reg == sksid_pkg::CMD_DELETE)
                            begin
                                res_next   = sksid_pkg::ST_MISS;
                                state_next = S_DONE;
                            end
                            else if (full)
                            begin
                                res_next   = sksid_pkg::ST_FULL;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = didx_reg;
                                mem_wdata  = key_reg;
                                carry_next = rdata_reg;
                                shift_next = 1'b1;
                            end
                        end
                    end
                    else if (cmd_reg == sksid_pkg::CMD_INSERT)
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = didx_reg;
                        mem_wdata  = carry_reg;
                        carry_next = rdata_reg;
                    end
                    else
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = didx_reg - IDX_W'(1);
                        mem_wdata = rdata_reg;
                    end
                end
                else if (rd_idx_reg == count_reg)
                begin
                    // pass over all stored keys complete
                    state_next = S_DONE;
                    if (cmd_reg == sksid_pkg::CMD_INSERT)
                    begin
                        if (!shift_reg && full)
                        begin
                            res_next = sksid_pkg::ST_FULL;
                        end
                        else
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = count_reg[IDX_W-1:0];
                            mem_wdata  = shift_reg ? carry_reg : key_reg;
                            count_next = count_reg + CNT_W'(1);
                            res_next   = sksid_pkg::ST_DONE;
                        end
                    end
                    else if (shift_reg)
                    begin
                        count_next = count_reg - CNT_W'(1);
                        res_next   = sksid_pkg::ST_DONE;
                    end
                    else
                    begin
                        res_next = sksid_pkg::ST_MISS;
                    end
                end

                // issue the next read while the pass goes on
                if (state_next == S_SCAN && rd_idx_reg < count_reg)
                begin
                    mem_re      = 1'b1;
                    rvalid_next = 1'b1;
                    didx_next   = rd_idx_reg[IDX_W-1:0];
                    rd_idx_next = rd_idx_reg + CNT_W'(1);
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    status_next    = res_reg;
                    entry_next     = sksid_pkg::ENTRY_W'(count_reg);
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rvalid_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rvalid_reg    <= rvalid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        rd_idx_reg <= rd_idx_next;
        didx_reg   <= didx_next;
        shift_reg  <= shift_next;
        cmd_reg    <= cmd_next;
        key_reg    <= key_next;
        carry_reg  <= carry_next;
        res_reg    <= res_next;
        status_reg <= status_next;
        entry_reg  <= entry_next;
    end

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_CNT)
        else $error("key count above capacity");

    a_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_SCAN))
        else $error("memory write outside a pass");

    a_read_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        rvalid_reg |-> (state_reg == S_SCAN))
        else $error("read data returned outside a pass");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg == sksid_pkg::ST_FULL)
            |-> (entry_reg == sksid_pkg::ENTRY_W'(CAP_CNT)))
        else $error("full status with store not full");

endmodule

`default_nettype wire

FILE: tb/sv/sorted_key_set_checker.sv
// sorted_key_set_checker: watches both channels of the sorted key set, predicts and compares
// depends on sksid_pkg; instantiated beside the block by tb
module sorted_key_set_checker
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic                               in_ready,
    input  logic                               cmd,
    input  logic signed [sksid_pkg::KEY_W-1:0] key,
    input  logic                               out_valid,
    input  logic                               out_ready,
    input  logic [sksid_pkg::STATUS_W-1:0]     status,
    input  logic [sksid_pkg::ENTRY_W-1:0]      entry_count,
    output int                                 fail_count,
    output int                                 pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [sksid_pkg::STATUS_W-1:0] status;
        logic [sksid_pkg::ENTRY_W-1:0]  count;
    } request_result_t;

    // predicted store contents, kept in ascending signed order
    logic signed [sksid_pkg::KEY_W-1:0] held_keys[$];
    // results predicted but not yet seen on the output channel
    request_result_t                    awaited_results[$];

    // apply one request to the predicted store and return its result
    function automatic request_result_t apply_request(
        input logic op,
        input logic signed [sksid_pkg::KEY_W-1:0] k);
        int              slot;
        bit              present;
        request_result_t r;
        slot = 0;
        while (slot < held_keys.size() && held_keys[slot] < k)
            slot++;
        present = (slot < held_keys.size()) && (held_keys[slot] == k);
        if (op == sksid_pkg::CMD_INSERT)
        begin
            // duplicate check comes before the full check
            if (present)
                r.status = sksid_pkg::ST_MISS;
            else if (held_keys.size() >= sksid_pkg::CAPACITY)
                r.status = sksid_pkg::ST_FULL;
            else
            begin
                held_keys.insert(slot, k);
                r.status = sksid_pkg::ST_DONE;
            end
        end
        else
        begin
            // only an exactly equal key is removed
            if (!present)
                r.status = sksid_pkg::ST_MISS;
            else
            begin
                held_keys.delete(slot);
                r.status = sksid_pkg::ST_DONE;
            end
        end
        r.count = sksid_pkg::ENTRY_W'(held_keys.size());
        return r;
    endfunction

    // compare results first, then record the new request: a result leaving at the
    // same edge always belongs to an earlier item
    always @(posedge clk or negedge rst_n)
    begin
        request_result_t want;
        if (!rst_n)
        begin
            held_keys.delete();
            awaited_results.delete();
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    $display("%0t: result with nothing awaited: status %0d count %0d",
                             $time, status, entry_count);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (status !== want.status || entry_count !== want.count)
                    begin
                        $display("%0t: status expected %0d got %0d, count expected %0d got %0d",
                                 $time, want.status, status, want.count, entry_count);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (in_valid && in_ready)
                awaited_results.push_back(apply_request(cmd, key));
            pending <= awaited_results.size();
        end
    end

endmodule

FILE: tb/sv/tb.sv
// tb: top of the sorted key set testbench, drives requests and the result handshake
// depends on sksid_pkg, sorted_key_set_insert_delete and sorted_key_set_checker
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int KEY_W    = sksid_pkg::KEY_W;
    localparam int STATUS_W = sksid_pkg::STATUS_W;
    localparam int ENTRY_W  = sksid_pkg::ENTRY_W;
    localparam int CAPACITY = sksid_pkg::CAPACITY;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int POOL_SIZE   = 24;
    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 150;
    localparam int DRAIN_WAIT  = 60;

    localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
    localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};

    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    in_valid  = 1'b0;
    logic                    in_ready;
    logic                    cmd       = sksid_pkg::CMD_INSERT;
    logic signed [KEY_W-1:0] key       = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic [STATUS_W-1:0]     status;
    logic [ENTRY_W-1:0]      entry_count;
    int                      fail_count;
    int                      pending;

    int                      cycle_count = 0;
    int                      hold_left   = 0;
    bit                      no_idling   = 1'b0;
    logic signed [KEY_W-1:0] key_pool[POOL_SIZE];

    always #4 clk = ~clk;

    sorted_key_set_insert_delete DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .key         (key),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .entry_count (entry_count)
    );

    sorted_key_set_checker u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .key         (key),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .entry_count (entry_count),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    function automatic int draw_idle();
        return no_idling ? 0 : int'($urandom_range(0, 19));
    endfunction

    // result side: after each item taken, hold ready low for a drawn number of cycles
    always @(posedge clk)
    begin
        int h;
        h = hold_left;
        if (out_valid && out_ready)
            h = draw_idle();
        else if (h > 0)
            h = h - 1;
        hold_left <= h;
        out_ready <= (h == 0);
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // present one request and wait until it is taken; valid stays high across
    // back-to-back items
    task automatic send_request(input logic op, input logic signed [KEY_W-1:0] k);
        int gap;
        gap = draw_idle();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= op;
        key      <= k;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // fresh key: full range, near zero, near the extremes, or in -65536 to 65535
    function automatic logic signed [KEY_W-1:0] fresh_key();
        int near;
        case ($urandom_range(0, 3))
            0: return $urandom;
            1:
            begin
                near = $urandom_range(0, 40);
                return near - 20;
            end
            2: return $urandom_range(0, 1) ? KEY_MIN + $urandom_range(0, 3)
                                           : KEY_MAX - $urandom_range(0, 3);
            default: return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom)};
        endcase
    endfunction

    initial
    begin
        int insert_pct;
        int slot;
        logic signed [KEY_W-1:0] k;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty store, only key, extremes, duplicates, absent key, full store
        send_request(sksid_pkg::CMD_DELETE, 32'sd5);
        send_request(sksid_pkg::CMD_INSERT, 32'sd7);
        send_request(sksid_pkg::CMD_DELETE, 32'sd7);
        send_request(sksid_pkg::CMD_INSERT, KEY_MIN);
        send_request(sksid_pkg::CMD_INSERT, KEY_MAX);
        send_request(sksid_pkg::CMD_INSERT, 32'sd0);
        send_request(sksid_pkg::CMD_INSERT, -32'sd1);
        send_request(sksid_pkg::CMD_INSERT, 32'sd0);
        send_request(sksid_pkg::CMD_DELETE, 32'sd1);
        for (int i = 1; i <= CAPACITY - 4; i++)
            send_request(sksid_pkg::CMD_INSERT, i * 1000 - 6500);
        send_request(sksid_pkg::CMD_INSERT, 32'sd42);
        send_request(sksid_pkg::CMD_INSERT, 32'sd0);
        send_request(sksid_pkg::CMD_DELETE, KEY_MIN);
        send_request(sksid_pkg::CMD_DELETE, KEY_MAX);

        // random phases over a small, changing key pool so keys come back often
        foreach (key_pool[i])
            key_pool[i] = fresh_key();
        for (int p = 0; p < PHASES; p++)
        begin
            case (p % 4)
                0: insert_pct = 80;
                1: insert_pct = 50;
                2: insert_pct = 20;
                default: insert_pct = 60;
            endcase
            no_idling = (p % 4 == 1);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                slot = $urandom_range(0, POOL_SIZE - 1);
                if ($urandom_range(0, 3) == 0)
                    key_pool[slot] = fresh_key();
                k = key_pool[slot];
                send_request(($urandom_range(0, 99) < insert_pct) ? sksid_pkg::CMD_INSERT
                                                                  : sksid_pkg::CMD_DELETE, k);
            end
        end
        in_valid <= 1'b0;
        no_idling = 1'b0;

        // drain, then allow time for any stray result
        @(posedge clk);
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/sksid_pkg.sv
rtl/core/sorted_key_set_insert_delete.sv
tb/sv/sorted_key_set_checker.sv
tb/sv/tb.sv
